[sv/dqu_pkg.sv]
package dqu_pkg;

  // queue geometry
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // fixed field widths of the words
  localparam int OP_W     = 3;
  localparam int WORD_W   = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_QUERY      = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE       = 2'd0,
    ST_PUSH_FULL  = 2'd1,
    ST_POP_EMPTY  = 2'd2
  } status_e;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [WORD_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
    logic [STATUS_W-1:0]      status;
  } out_word_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic load_front;
    logic load_back;
    logic drop_front;
    logic drop_back;
  } cell_cmd_t;

  // sign-extend a stored element to the output word width
  function automatic logic [WORD_W-1:0] ext_word(input logic [DATA_WIDTH-1:0] d);
    logic signed [DATA_WIDTH+WORD_W-1:0] wide;
    wide = (DATA_WIDTH + WORD_W)'(signed'(d));
    return wide[WORD_W-1:0];
  endfunction

endpackage

[sv/dqu_cell.sv]
module dqu_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dqu_pkg::cell_cmd_t             cmd,
  input  logic                           left_valid,
  input  logic [dqu_pkg::DATA_WIDTH-1:0] left_data,
  input  logic                           right_valid,
  input  logic [dqu_pkg::DATA_WIDTH-1:0] right_data,
  input  logic [dqu_pkg::DATA_WIDTH-1:0] push_data,
  output logic                           valid,
  output logic [dqu_pkg::DATA_WIDTH-1:0] data
);
  import dqu_pkg::*;

  logic                  valid_r, valid_nxt;
  logic [DATA_WIDTH-1:0] data_r, data_nxt;

  // occupancy: pushes shift the fill mark right, pops shift it left
  always_comb begin
    valid_nxt = valid_r;
    if (cmd.load_front || cmd.load_back) begin
      valid_nxt = left_valid;
    end else if (cmd.drop_front || cmd.drop_back) begin
      valid_nxt = right_valid;
    end
  end

  // element: shift toward the back, toward the front, or load at the fill edge
  always_comb begin
    data_nxt = data_r;
    if (cmd.load_front) begin
      data_nxt = left_data;
    end else if (cmd.load_back && !valid_r && left_valid) begin
      data_nxt = push_data;
    end else if (cmd.drop_front) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid = valid_r;
  assign data  = data_r;

endmodule

[sv/bounded_double_ended_queue_unit.sv]
// Double-ended queue of up to DEPTH signed words held in a row of cells, front
// in the first cell. Every operation word is taken in one cycle and busy stays
// low, so a new word may follow in every cycle; the row of cells updates once
// per word. The result word appears one cycle after acceptance, marked by
// out_strobe for exactly that one cycle: the receiver cannot stall and must
// capture it then. A push into a full queue or a pop from an empty one leaves
// the contents as they were and is flagged in the status field.
module bounded_double_ended_queue_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  dqu_pkg::in_word_t  in_word,
  output logic               out_strobe,
  output dqu_pkg::out_word_t out_word
);
  import dqu_pkg::*;

  logic                  accept;
  logic                  full, empty;
  op_e                   op;
  cell_cmd_t             cmd;
  status_e               status_nxt, status_r;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  out_strobe_r;
  logic [DEPTH-1:0]      cell_valid;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]      is_back;
  logic [DATA_WIDTH-1:0] back_data;
  logic [DATA_WIDTH-1:0] push_data;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign op     = op_e'(in_word.op);
  assign full   = cell_valid[DEPTH-1];
  assign empty  = !cell_valid[0];
  assign push_data = in_word.value[DATA_WIDTH-1:0];

  // decode the operation into a cell command, a new count and a status
  always_comb begin
    cmd        = '0;
    status_nxt = ST_DONE;
    count_nxt  = count_r;
    if (accept) begin
      case (op)
        OP_PUSH_BACK, OP_PUSH_FRONT: begin
          if (full) begin
            status_nxt = ST_PUSH_FULL;
          end else begin
            cmd.load_back  = (op == OP_PUSH_BACK);
            cmd.load_front = (op == OP_PUSH_FRONT);
            count_nxt      = count_r + CNT_W'(1);
          end
        end
        OP_POP_BACK, OP_POP_FRONT: begin
          if (empty) begin
            status_nxt = ST_POP_EMPTY;
          end else begin
            cmd.drop_back  = (op == OP_POP_BACK);
            cmd.drop_front = (op == OP_POP_FRONT);
            count_nxt      = count_r - CNT_W'(1);
          end
        end
        default: begin
          status_nxt = ST_DONE;
        end
      endcase
    end
  end

  // row of cells fed by neighbors; the first cell's left input is the pushed word
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  lv, rv;
    logic [DATA_WIDTH-1:0] ld, rd;
    if (i == 0) begin : g_first
      assign lv = 1'b1;
      assign ld = push_data;
    end else begin : g_mid_l
      assign lv = cell_valid[i-1];
      assign ld = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rv = 1'b0;
      assign rd = '0;
    end else begin : g_mid_r
      assign rv = cell_valid[i+1];
      assign rd = cell_data[i+1];
    end
    dqu_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .left_valid  (lv),
      .left_data   (ld),
      .right_valid (rv),
      .right_data  (rd),
      .push_data   (push_data),
      .valid       (cell_valid[i]),
      .data        (cell_data[i])
    );
  end

  // the back element sits in the last occupied cell
  assign is_back = cell_valid & ~{1'b0, cell_valid[DEPTH-1:1]};

  always_comb begin
    back_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (is_back[i]) begin
        back_data = back_data | cell_data[i];
      end
    end
  end

  // count, strobe and status registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      out_strobe_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
    end
  end

  // result word, taken from the cell row after the update
  assign out_strobe           = out_strobe_r;
  assign out_word.front_value = empty ? '0 : ext_word(cell_data[0]);
  assign out_word.back_value  = empty ? '0 : ext_word(back_data);
  assign out_word.count       = COUNT_W'(count_r);
  assign out_word.is_empty    = empty;
  assign out_word.status      = status_r;

  // occupancy is a fill mark starting at the front cell
  a_thermometer: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid + DEPTH'(1)) & cell_valid) == '0)
    else $error("cell occupancy is not contiguous from the front");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) == $countones(cell_valid))
    else $error("count disagrees with occupied cells");

  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_strobe)
    else $error("accepted word gave no result");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.status == ST_PUSH_FULL) |-> (int'(count_r) == DEPTH))
    else $error("push rejected while queue not full");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.status == ST_POP_EMPTY) |-> out_word.is_empty)
    else $error("pop ignored while queue not empty");

endmodule

[sim/tb_bounded_double_ended_queue_unit.sv]
`timescale 1ns / 100ps

module tb_bounded_double_ended_queue_unit;
  import dqu_pkg::*;

  // spare op codes, all handled as a plain query
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  // traffic shapes for the random part
  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIX   = 2;

  localparam int RANDOM_WORDS = 600;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_CAP   = 40;

  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_NEG1 = -32'sd1;

  // one line of the directed script, with an optional hand-written answer
  typedef struct {
    logic [OP_W-1:0]          op;
    logic signed [WORD_W-1:0] value;
    int                       reps;
    bit                       pinned;
    out_word_t                answer;
  } script_row_t;

  typedef struct {
    bit        pinned;
    out_word_t answer;
  } known_answer_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_strobe;
  out_word_t out_word;

  bounded_double_ended_queue_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the deque, held as a ring buffer
  logic [DATA_WIDTH-1:0] ring_words [DEPTH];
  int unsigned           ring_head = 0;
  int unsigned           ring_fill = 0;

  out_word_t     awaited_results [$];
  known_answer_t known_answers [$];
  int            accepted_count = 0;
  int            checked_count = 0;
  int            mismatch_count = 0;
  script_row_t   script [19];

  // stored element widened to the output word
  function automatic logic [WORD_W-1:0] widen(input logic [DATA_WIDTH-1:0] d);
    logic signed [63:0] wide;
    wide = 64'(signed'(d));
    return wide[WORD_W-1:0];
  endfunction

  // apply one operation word to the shadow deque and return its result word
  function automatic out_word_t deque_apply(input in_word_t w);
    out_word_t r;
    r = '0;
    r.status = ST_DONE;
    case (w.op)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (ring_fill >= DEPTH) begin
          r.status = ST_PUSH_FULL;
        end else if (w.op == OP_PUSH_BACK) begin
          ring_words[(ring_head + ring_fill) % DEPTH] = DATA_WIDTH'($unsigned(w.value));
          ring_fill++;
        end else begin
          ring_head = (ring_head + DEPTH - 1) % DEPTH;
          ring_words[ring_head] = DATA_WIDTH'($unsigned(w.value));
          ring_fill++;
        end
      end
      OP_POP_BACK, OP_POP_FRONT: begin
        if (ring_fill == 0) begin
          r.status = ST_POP_EMPTY;
        end else begin
          if (w.op == OP_POP_FRONT) ring_head = (ring_head + 1) % DEPTH;
          ring_fill--;
        end
      end
      default: ;
    endcase
    if (ring_fill == 0) begin
      r.is_empty = 1'b1;
    end else begin
      r.front_value = widen(ring_words[ring_head]);
      r.back_value  = widen(ring_words[(ring_head + ring_fill - 1) % DEPTH]);
    end
    r.count = COUNT_W'(ring_fill);
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
    end
  endtask

  // acceptance and result check, both sampled at the rising edge
  out_word_t     predicted;
  out_word_t     want;
  known_answer_t answer;

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        answer = '{pinned: 1'b0, answer: '0};
        if (known_answers.size() != 0) begin
          answer = known_answers[0];
          known_answers.delete(0);
        end
        predicted = deque_apply(in_word);
        awaited_results.insert(awaited_results.size(),
                               answer.pinned ? answer.answer : predicted);
      end
      if (out_strobe) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_CAP)
            $display("%0t: unexpected result word, expected none, actual %h",
                     $time, out_word);
        end else begin
          want = awaited_results[0];
          awaited_results.delete(0);
          check_field("front_value", want.front_value, out_word.front_value);
          check_field("back_value", want.back_value, out_word.back_value);
          check_field("count", WORD_W'(want.count), WORD_W'(out_word.count));
          check_field("is_empty", WORD_W'(want.is_empty), WORD_W'(out_word.is_empty));
          check_field("status", WORD_W'(want.status), WORD_W'(out_word.status));
          checked_count++;
        end
      end
    end
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // offer one word and hold it until taken
  task automatic issue_word(input in_word_t w, input bit pinned, input out_word_t ans);
    known_answer_t ka;
    ka.pinned = pinned;
    ka.answer = ans;
    known_answers.insert(known_answers.size(), ka);
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    accepted_count++;
  endtask

  // drop start and put junk on the word bus for an idle gap
  task automatic idle_gap(input int n);
    in_word_t junk;
    if (n > 0) begin
      junk.op    = OP_W'($urandom);
      junk.value = $urandom;
      start   <= 1'b0;
      in_word <= junk;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold off until every result so far has been checked
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (checked_count != accepted_count) @(posedge clk);
  endtask

  function automatic script_row_t row(input logic [OP_W-1:0] op,
                                      input logic signed [WORD_W-1:0] value, input int reps,
                                      input bit pinned, input logic signed [WORD_W-1:0] fv,
                                      input logic signed [WORD_W-1:0] bv, input int cnt,
                                      input bit empty, input status_e st);
    script_row_t r;
    r.op = op;
    r.value = value;
    r.reps = reps;
    r.pinned = pinned;
    r.answer.front_value = fv;
    r.answer.back_value = bv;
    r.answer.count = COUNT_W'(cnt);
    r.answer.is_empty = empty;
    r.answer.status = st;
    return r;
  endfunction

  function automatic in_word_t random_word(input int mode);
    in_word_t w;
    int       r;
    int       push_pct;
    r = $urandom_range(0, 99);
    push_pct = (mode == MODE_FILL) ? 70 : (mode == MODE_DRAIN) ? 25 : 48;
    if (r < 5)
      w.op = OP_W'($urandom_range(OP_SPARE_A, OP_SPARE_C));
    else if (r < 12)
      w.op = OP_QUERY;
    else if (r < 12 + push_pct * 88 / 100)
      w.op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    else
      w.op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
    case ($urandom_range(0, 9))
      0: w.value = WORD_MAX;
      1: w.value = WORD_MIN;
      2: w.value = $urandom_range(0, 1) ? WORD_NEG1 : '0;
      default: w.value = $urandom;
    endcase
    return w;
  endfunction

  // stimulus
  initial begin
    in_word_t w;
    int       left;
    int       burst;
    int       mode;
    bit       paused;

    // empty queue, extremes, spare codes, last element popped, full queue
    script[0]  = row(OP_POP_FRONT, 0, 1, 1, 0, 0, 0, 1, ST_POP_EMPTY);
    script[1]  = row(OP_POP_BACK, 0, 1, 1, 0, 0, 0, 1, ST_POP_EMPTY);
    script[2]  = row(OP_QUERY, 0, 1, 1, 0, 0, 0, 1, ST_DONE);
    script[3]  = row(OP_PUSH_BACK, WORD_MAX, 1, 1, WORD_MAX, WORD_MAX, 1, 0, ST_DONE);
    script[4]  = row(OP_PUSH_FRONT, WORD_MIN, 1, 1, WORD_MIN, WORD_MAX, 2, 0, ST_DONE);
    script[5]  = row(OP_SPARE_A, 32'sh1234_5678, 1, 1, WORD_MIN, WORD_MAX, 2, 0, ST_DONE);
    script[6]  = row(OP_SPARE_B, WORD_NEG1, 1, 0, 0, 0, 0, 0, ST_DONE);
    script[7]  = row(OP_SPARE_C, 0, 1, 0, 0, 0, 0, 0, ST_DONE);
    script[8]  = row(OP_POP_BACK, 0, 1, 1, WORD_MIN, WORD_MIN, 1, 0, ST_DONE);
    script[9]  = row(OP_POP_FRONT, 0, 1, 1, 0, 0, 0, 1, ST_DONE);
    script[10] = row(OP_PUSH_FRONT, 0, 1, 0, 0, 0, 0, 0, ST_DONE);
    script[11] = row(OP_PUSH_BACK, WORD_NEG1, DEPTH - 1, 0, 0, 0, 0, 0, ST_DONE);
    script[12] = row(OP_PUSH_FRONT, 32'sh5a5a_5a5a, 1, 1, 0, WORD_NEG1, DEPTH, 0,
                     ST_PUSH_FULL);
    script[13] = row(OP_PUSH_BACK, 1, 1, 1, 0, WORD_NEG1, DEPTH, 0, ST_PUSH_FULL);
    script[14] = row(OP_QUERY, 0, 1, 0, 0, 0, 0, 0, ST_DONE);
    script[15] = row(OP_POP_FRONT, 0, 1, 0, 0, 0, 0, 0, ST_DONE);
    script[16] = row(OP_POP_BACK, 0, DEPTH - 2, 0, 0, 0, 0, 0, ST_DONE);
    script[17] = row(OP_POP_FRONT, 0, 1, 1, 0, 0, 0, 1, ST_DONE);
    script[18] = row(OP_POP_BACK, 0, 1, 1, 0, 0, 0, 1, ST_POP_EMPTY);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed script
    foreach (script[i]) begin
      for (int k = 0; k < script[i].reps; k++) begin
        w.op = script[i].op;
        w.value = script[i].value;
        issue_word(w, script[i].pinned, script[i].answer);
        if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 4));
      end
    end
    wait_drained();

    // random bursts, each shape held for a few bursts to reach full and empty
    left = RANDOM_WORDS;
    mode = MODE_FILL;
    paused = 1'b0;
    while (left > 0) begin
      if ($urandom_range(0, 3) == 0) mode = $urandom_range(MODE_FILL, MODE_MIX);
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      for (int k = 0; k < burst && left > 0; k++) begin
        issue_word(random_word(mode), 1'b0, '0);
        left--;
      end
      if (!paused && left < RANDOM_WORDS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      idle_gap($urandom_range(0, 6));
    end

    // drain and settle
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0) begin
      mismatch_count += awaited_results.size();
      $display("%0t: %0d result words never arrived", $time, awaited_results.size());
    end
    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
